// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the rtl top level
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds on every clock outside reset
`define SFL_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define SFL_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hw/rtl/sfl_pkg.sv =====
// types, codes and constants of the slot allocator with free list queue
// no dependencies
package sfl_pkg;

   localparam int SLOTS_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam int OP_W     = 2;
   localparam int DATA_W   = 32;
   localparam int SLOT_W   = 4;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 5;

   localparam int MAX_LIMIT = 16;
   localparam int MAX_RESET = 16;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic REG_MAX_ENTRIES = 1'b0;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_READ   = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 3'd0,
      STATUS_FULL     = 3'd1,
      STATUS_EMPTY    = 3'd2,
      STATUS_DISABLED = 3'd3,
      STATUS_BAD_SLOT = 3'd4
   } status_type;

   typedef struct packed {
      logic [OP_W-1:0]   req_type;
      logic [DATA_W-1:0] data_in;
      logic [SLOT_W-1:0] slot_in;
   } req_payload_type;

   typedef struct packed {
      status_type         status;
      logic [SLOT_W-1:0]  slot_out;
      logic [DATA_W-1:0]  read_data;
      logic [COUNT_W-1:0] entry_count;
      logic               full_flag;
      logic               empty_flag;
   } rsp_payload_type;

endpackage

// ===== hw/rtl/sfl_req_if.sv =====
// request channel: valid, ready and request payload
// depends on sfl_pkg
interface sfl_req_if;
   import sfl_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/sfl_rsp_if.sv =====
// result channel: valid, ready and result payload
// depends on sfl_pkg
interface sfl_rsp_if;
   import sfl_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/slot_allocator_fifo_free_list_unit.sv =====
// slot allocator top level: data store and free slot queue in synchronous memories
// depends on sfl_pkg, sfl_req_if, sfl_rsp_if and assert_macros.svh
//
// Usage: requests arrive on req_chan (insert, remove, read, clear all) and one
// result per request leaves on rsp_chan with status, granted slot, read word,
// occupancy count and full and empty flags. Channels use valid and ready;
// a request is taken when both are high.
// Timing: when a request is taken, the free queue and data store are read into
// their read registers at that edge; in the lookup state, once the result
// register is free, the block decides, writes the memories back and loads the
// result register. A new request is taken only in the idle state.
// A result waiting on a stalled receiver does not stop the next request from
// being taken and read; it is decided once the result register frees up.
// Clear all, and a write of max_entries on the APB port, reinitialise without
// touching the memories: per entry valid bits make unwritten store words read
// as zero and unwritten queue entries read as their own index.
// Reset: synchronous, active high; max_entries returns to 16 (capped at SLOTS),
// count and pointers return to zero, the store reads all zero.
// max_entries of zero disables the block: every request reports disabled.
module slot_allocator_fifo_free_list_unit #(
   parameter int SLOTS      = sfl_pkg::SLOTS_DEFAULT,
   parameter int DATA_WIDTH = sfl_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   sfl_req_if.sink                       req_chan,
   sfl_rsp_if.source                     rsp_chan,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [sfl_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [sfl_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [sfl_pkg::CSR_DATA_W-1:0] prdata,
   output logic                          pready
);
   import sfl_pkg::*;

   `include "assert_macros.svh"

   localparam int DEPTH   = (SLOTS > MAX_LIMIT) ? MAX_LIMIT : SLOTS;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int STORE_W = (DATA_WIDTH < DATA_W) ? DATA_WIDTH : DATA_W;
   localparam int WIDE_W  = IDX_W + COUNT_W;
   localparam int RST_MAX = (MAX_RESET > DEPTH) ? DEPTH : MAX_RESET;

   typedef enum logic {
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   // memories
   logic [STORE_W-1:0] store_mem [DEPTH];
   logic [IDX_W-1:0]   queue_mem [DEPTH];
   logic [DEPTH-1:0]   store_valid_ff, store_valid_in;
   logic [DEPTH-1:0]   queue_valid_ff, queue_valid_in;

   logic [STORE_W-1:0] store_rd_ff;
   logic [IDX_W-1:0]   queue_rd_ff;
   logic               store_rd_valid_ff;
   logic               queue_rd_valid_ff;

   logic               store_we;
   logic [IDX_W-1:0]   store_waddr;
   logic [STORE_W-1:0] store_wdata;
   logic               queue_we;
   logic [IDX_W-1:0]   queue_waddr;
   logic [IDX_W-1:0]   queue_wdata;

   // control state
   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] max_ff, max_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0]   take_ptr_ff, take_ptr_in;
   logic [IDX_W-1:0]   ret_ptr_ff, ret_ptr_in;

   // latched request
   logic [OP_W-1:0]    op_ff, op_in;
   logic [STORE_W-1:0] data_ff, data_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_ff, rsp_in;

   logic               accept;
   logic               out_free;
   logic               cfg_we;
   logic [COUNT_W-1:0] cfg_max;
   logic [IDX_W-1:0]   req_idx;
   logic [IDX_W-1:0]   slot_idx;
   logic [IDX_W-1:0]   grant_idx;
   logic               slot_bad;
   logic [WIDE_W-1:0]  take_inc;
   logic [WIDE_W-1:0]  ret_inc;

   assign accept   = req_chan.valid && (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_idx  = IDX_W'(req_chan.payload.slot_in);
   assign slot_idx = IDX_W'(slot_ff);
   assign slot_bad = COUNT_W'(slot_ff) >= max_ff;
   assign grant_idx = queue_rd_valid_ff ? queue_rd_ff : take_ptr_ff;
   assign take_inc = WIDE_W'(take_ptr_ff) + WIDE_W'(1);
   assign ret_inc  = WIDE_W'(ret_ptr_ff) + WIDE_W'(1);

   assign req_chan.ready   = (state_ff == ST_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   // apb register
   assign pready  = 1'b1;
   assign cfg_we  = psel && penable && pwrite && (paddr[2] == REG_MAX_ENTRIES);
   assign cfg_max = (WIDE_W'(pwdata[COUNT_W-1:0]) > WIDE_W'(DEPTH)) ?
                    COUNT_W'(DEPTH) : pwdata[COUNT_W-1:0];
   assign prdata  = (paddr[2] == REG_MAX_ENTRIES) ? CSR_DATA_W'(max_ff) : '0;

   always_comb begin
      state_in       = state_ff;
      max_in         = max_ff;
      count_in       = count_ff;
      take_ptr_in    = take_ptr_ff;
      ret_ptr_in     = ret_ptr_ff;
      store_valid_in = store_valid_ff;
      queue_valid_in = queue_valid_ff;
      op_in          = op_ff;
      data_in        = data_ff;
      slot_in        = slot_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_in         = rsp_ff;
      store_we       = 1'b0;
      store_waddr    = slot_idx;
      store_wdata    = data_ff;
      queue_we       = 1'b0;
      queue_waddr    = ret_ptr_ff;
      queue_wdata    = slot_idx;

      if (accept) begin
         op_in    = req_chan.payload.req_type;
         data_in  = req_chan.payload.data_in[STORE_W-1:0];
         slot_in  = req_chan.payload.slot_in;
         state_in = ST_LOOKUP;
      end

      if ((state_ff == ST_LOOKUP) && out_free) begin
         state_in         = ST_IDLE;
         rsp_valid_in     = 1'b1;
         rsp_in.status    = STATUS_OK;
         rsp_in.slot_out  = '0;
         rsp_in.read_data = '0;
         if (max_ff == '0) begin
            rsp_in.status = STATUS_DISABLED;
         end else begin
            unique case (op_type'(op_ff))
               OP_INSERT: begin
                  if (count_ff >= max_ff) begin
                     rsp_in.status = STATUS_FULL;
                  end else begin
                     store_we                  = 1'b1;
                     store_waddr               = grant_idx;
                     store_valid_in[grant_idx] = 1'b1;
                     take_ptr_in = (take_inc == WIDE_W'(max_ff)) ? '0 : take_inc[IDX_W-1:0];
                     count_in    = count_ff + COUNT_W'(1);
                     rsp_in.slot_out = SLOT_W'(grant_idx);
                  end
               end
               OP_REMOVE: begin
                  if (count_ff == '0) begin
                     rsp_in.status = STATUS_EMPTY;
                  end else if (slot_bad) begin
                     rsp_in.status = STATUS_BAD_SLOT;
                  end else begin
                     store_valid_in[slot_idx]   = 1'b0;
                     queue_we                   = 1'b1;
                     queue_valid_in[ret_ptr_ff] = 1'b1;
                     ret_ptr_in = (ret_inc == WIDE_W'(max_ff)) ? '0 : ret_inc[IDX_W-1:0];
                     count_in   = count_ff - COUNT_W'(1);
                  end
               end
               OP_READ: begin
                  if (slot_bad) begin
                     rsp_in.status = STATUS_BAD_SLOT;
                  end else if (store_rd_valid_ff) begin
                     rsp_in.read_data = DATA_W'(store_rd_ff);
                  end
               end
               OP_CLEAR: begin
                  store_valid_in = '0;
                  queue_valid_in = '0;
                  take_ptr_in    = '0;
                  ret_ptr_in     = '0;
                  count_in       = '0;
               end
               default: begin
                  rsp_in.status = STATUS_OK;
               end
            endcase
         end
         rsp_in.entry_count = count_in;
         rsp_in.full_flag   = (max_ff != '0) && (count_in >= max_ff);
         rsp_in.empty_flag  = (count_in == '0);
      end

      if (cfg_we) begin
         max_in         = cfg_max;
         store_valid_in = '0;
         queue_valid_in = '0;
         take_ptr_in    = '0;
         ret_ptr_in     = '0;
         count_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         max_ff         <= COUNT_W'(RST_MAX);
         count_ff       <= '0;
         take_ptr_ff    <= '0;
         ret_ptr_ff     <= '0;
         store_valid_ff <= '0;
         queue_valid_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         max_ff         <= max_in;
         count_ff       <= count_in;
         take_ptr_ff    <= take_ptr_in;
         ret_ptr_ff     <= ret_ptr_in;
         store_valid_ff <= store_valid_in;
         queue_valid_ff <= queue_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      op_ff   <= op_in;
      data_ff <= data_in;
      slot_ff <= slot_in;
      rsp_ff  <= rsp_in;
   end

   // data store: read on request, written back in the lookup cycle
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[store_waddr] <= store_wdata;
      end
      if (accept) begin
         store_rd_ff       <= store_mem[req_idx];
         store_rd_valid_ff <= store_valid_ff[req_idx];
      end
   end

   // free slot queue
   always_ff @(posedge clock) begin
      if (queue_we) begin
         queue_mem[queue_waddr] <= queue_wdata;
      end
      if (accept) begin
         queue_rd_ff       <= queue_mem[take_ptr_ff];
         queue_rd_valid_ff <= queue_valid_ff[take_ptr_ff];
      end
   end

   `SFL_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= max_ff,
      "occupancy above max_entries")
   `SFL_ASSERT_IMPLIES(a_disabled_idle, clock, reset, max_ff == '0,
      (count_ff == '0) && (take_ptr_ff == '0) && (ret_ptr_ff == '0),
      "disabled block holds state")
   `SFL_ASSERT_IMPLIES(a_ptr_range, clock, reset, max_ff != '0,
      (WIDE_W'(take_ptr_ff) < WIDE_W'(max_ff)) && (WIDE_W'(ret_ptr_ff) < WIDE_W'(max_ff)),
      "queue pointer beyond max_entries")

endmodule
